@@ src/fbc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants for the frustum box cull block
// Register indexes, matrix layout, reset matrix and the control word that
// travels from cell to cell along the plane chain.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int NUM_PLANES   = 6;
  localparam int NUM_COLS     = 4;
  localparam int NUM_AXES     = 3;
  localparam int FIELD_STRIDE = 16;
  localparam int W_ROW        = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 8;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MATRIX_COL0 = 8'd0,
    REG_MATRIX_COL1 = 8'd1,
    REG_MATRIX_COL2 = 8'd2,
    REG_MATRIX_COL3 = 8'd3
  } reg_index_t;

  // identity matrix, one column per register
  localparam logic [CFG_DATA_W-1:0] RESET_COL [NUM_COLS] = '{
    64'h0000_0000_0000_0100,
    64'h0000_0000_0100_0000,
    64'h0000_0100_0000_0000,
    64'h0100_0000_0000_0000
  };

  // control word handed along the chain
  typedef struct packed {
    logic valid;
    logic visible;
  } cull_ctl_t;

endpackage

@@ src/fbc_cell.sv @@
// ----------------------------------------------------------------------------
// fbc_cell: one plane test of the cull chain
// Picks the corner farthest along the plane normal, multiplies it by the
// plane coefficients, adds the offset and clears the visible flag on a
// negative distance. Two register stages, elastic handshake to both sides.
// ----------------------------------------------------------------------------
module fbc_cell #(
  parameter int COORD_WIDTH = 24,
  parameter int COEFF_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [COEFF_WIDTH:0]   coef      [fbc_pkg::NUM_COLS],
  input  fbc_pkg::cull_ctl_t            in_ctl,
  input  logic signed [COORD_WIDTH-1:0] in_lo     [fbc_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] in_hi     [fbc_pkg::NUM_AXES],
  output logic                          in_ready,
  output fbc_pkg::cull_ctl_t            out_ctl,
  output logic signed [COORD_WIDTH-1:0] out_lo    [fbc_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH-1:0] out_hi    [fbc_pkg::NUM_AXES],
  input  logic                          out_ready
);
  import fbc_pkg::*;

  localparam int PROD_W = COEFF_WIDTH + 1 + COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int OFS_W  = COEFF_WIDTH + 1 + 8;

  // product stage
  cull_ctl_t                   s1_ctl;
  logic signed [PROD_W-1:0]    s1_prod [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] s1_lo [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] s1_hi [NUM_AXES];

  // sum stage
  cull_ctl_t                   s2_ctl;

  logic s1_free;
  logic s2_free;
  logic signed [COORD_WIDTH-1:0] corner [NUM_AXES];
  logic signed [OFS_W-1:0]       offset;
  logic signed [SUM_W-1:0]       plane_sum;

  assign s2_free  = !s2_ctl.valid || out_ready;
  assign s1_free  = !s1_ctl.valid || s2_free;
  assign in_ready = s1_free;
  assign out_ctl  = s2_ctl;

  // pick the far corner per axis
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      corner[a] = coef[a][COEFF_WIDTH] ? in_lo[a] : in_hi[a];
    end
  end

  // offset term scaled to the product format
  assign offset = {coef[W_ROW], 8'b0};

  // plane distance of the registered products
  always_comb begin
    plane_sum = SUM_W'(s1_prod[0]) + SUM_W'(s1_prod[1]) + SUM_W'(s1_prod[2])
              + SUM_W'(offset);
  end

  // advance control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
    end else begin
      if (s1_free) begin
        s1_ctl <= in_ctl;
      end
      if (s2_free) begin
        s2_ctl.valid   <= s1_ctl.valid;
        s2_ctl.visible <= s1_ctl.visible & ~plane_sum[SUM_W-1];
      end
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (s1_free) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        s1_prod[a] <= PROD_W'(coef[a] * corner[a]);
        s1_lo[a]   <= in_lo[a];
        s1_hi[a]   <= in_hi[a];
      end
    end
    if (s2_free) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        out_lo[a] <= s1_lo[a];
        out_hi[a] <= s1_hi[a];
      end
    end
  end

endmodule

@@ src/frustum_box_cull.sv @@
// Each box passes through the product and sum registers of every plane cell.
// Throughput: one box per cycle while out_ready is high; six cells in a row,
// one per frustum plane, each with its own multipliers, so a new box can
// enter every cycle. Reset: synchronous, clears the valid flag of every
// pipeline stage and loads the identity matrix into the plane coefficients.
// ----------------------------------------------------------------------------
// frustum_box_cull: view frustum culling of axis-aligned boxes
// Keeps the six plane coefficient sets formed from the matrix columns and
// runs each box through a chain of plane cells.
// ----------------------------------------------------------------------------
module frustum_box_cull #(
  parameter int COORD_WIDTH = 24,
  parameter int COEFF_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   min_x,
  input  logic signed [COORD_WIDTH-1:0]   min_y,
  input  logic signed [COORD_WIDTH-1:0]   min_z,
  input  logic signed [COORD_WIDTH-1:0]   max_x,
  input  logic signed [COORD_WIDTH-1:0]   max_y,
  input  logic signed [COORD_WIDTH-1:0]   max_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            visible
);
  import fbc_pkg::*;

  // plane p, column c: row3 plus or minus row (p >> 1) of column c
  function automatic logic signed [COEFF_WIDTH:0] plane_coef(
    input logic [CFG_DATA_W-1:0] col,
    input int unsigned           p
  );
    logic signed [COEFF_WIDTH-1:0] r3;
    logic signed [COEFF_WIDTH-1:0] rr;
    logic signed [COEFF_WIDTH:0]   r3x;
    logic signed [COEFF_WIDTH:0]   rrx;
    r3  = col[W_ROW*FIELD_STRIDE +: COEFF_WIDTH];
    rr  = col[(p >> 1)*FIELD_STRIDE +: COEFF_WIDTH];
    r3x = {r3[COEFF_WIDTH-1], r3};
    rrx = {rr[COEFF_WIDTH-1], rr};
    return (p[0]) ? (r3x - rrx) : (r3x + rrx);
  endfunction

  logic signed [COEFF_WIDTH:0] coef [NUM_PLANES][NUM_COLS];

  cull_ctl_t                     ctl_chain   [NUM_PLANES+1];
  logic                          ready_chain [NUM_PLANES+1];
  logic signed [COORD_WIDTH-1:0] lo_chain    [NUM_PLANES+1][NUM_AXES];
  logic signed [COORD_WIDTH-1:0] hi_chain    [NUM_PLANES+1][NUM_AXES];

  assign cfg_ready = 1'b1;

  // load plane coefficients of the written column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          coef[p][c] <= plane_coef(RESET_COL[c], p);
        end
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MATRIX_COL0: begin
          for (int p = 0; p < NUM_PLANES; p++) coef[p][0] <= plane_coef(cfg_data, p);
        end
        REG_MATRIX_COL1: begin
          for (int p = 0; p < NUM_PLANES; p++) coef[p][1] <= plane_coef(cfg_data, p);
        end
        REG_MATRIX_COL2: begin
          for (int p = 0; p < NUM_PLANES; p++) coef[p][2] <= plane_coef(cfg_data, p);
        end
        REG_MATRIX_COL3: begin
          for (int p = 0; p < NUM_PLANES; p++) coef[p][3] <= plane_coef(cfg_data, p);
        end
        default: begin
        end
      endcase
    end
  end

  // feed the head of the chain
  assign ctl_chain[0].valid   = in_valid;
  assign ctl_chain[0].visible = 1'b1;
  assign lo_chain[0][0] = min_x;
  assign lo_chain[0][1] = min_y;
  assign lo_chain[0][2] = min_z;
  assign hi_chain[0][0] = max_x;
  assign hi_chain[0][1] = max_y;
  assign hi_chain[0][2] = max_z;
  assign in_ready = ready_chain[0];

  // one cell per plane
  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    fbc_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEFF_WIDTH (COEFF_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .coef      (coef[i]),
      .in_ctl    (ctl_chain[i]),
      .in_lo     (lo_chain[i]),
      .in_hi     (hi_chain[i]),
      .in_ready  (ready_chain[i]),
      .out_ctl   (ctl_chain[i+1]),
      .out_lo    (lo_chain[i+1]),
      .out_hi    (hi_chain[i+1]),
      .out_ready (ready_chain[i+1])
    );
  end

  // drive the result from the tail of the chain
  assign ready_chain[NUM_PLANES] = out_ready;
  assign out_valid = ctl_chain[NUM_PLANES].valid;
  assign visible   = ctl_chain[NUM_PLANES].visible;

endmodule

@@ bench/frustum_box_cull_check.sv @@
// ----------------------------------------------------------------------------
// frustum_box_cull_check: result checker for the frustum box cull block
// Tracks register writes, forms the six frustum planes from its own copy of
// the matrix, predicts the visible flag of every box that is transferred in,
// and compares each transferred result against the oldest prediction.
// ----------------------------------------------------------------------------
module frustum_box_cull_check #(
  parameter int COORD_WIDTH = 24,
  parameter int COEFF_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [fbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   min_x,
  input  logic signed [COORD_WIDTH-1:0]   min_y,
  input  logic signed [COORD_WIDTH-1:0]   min_z,
  input  logic signed [COORD_WIDTH-1:0]   max_x,
  input  logic signed [COORD_WIDTH-1:0]   max_y,
  input  logic signed [COORD_WIDTH-1:0]   max_z,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            visible,
  output int                              pending,
  output int                              mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  import fbc_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [CFG_DATA_W-1:0] mat_col [NUM_COLS];
  logic                  visibility_due [$];
  int                    results_seen;

  initial begin
    pending    = 0;
    mismatches = 0;
  end

  // signed Q8.8 coefficient of one matrix entry
  function automatic longint matrix_coeff(input int col, input int row);
    logic signed [COEFF_WIDTH-1:0] k;
    k = mat_col[col][FIELD_STRIDE*row +: COEFF_WIDTH];
    return k;
  endfunction

  // positive-vertex test of one box against all six planes
  function automatic logic box_visible(
    input logic signed [COORD_WIDTH-1:0] lx, ly, lz, hx, hy, hz
  );
    longint lo [NUM_AXES];
    longint hi [NUM_AXES];
    longint plane [NUM_COLS];
    longint acc;
    logic   seen;
    lo[0] = lx;
    lo[1] = ly;
    lo[2] = lz;
    hi[0] = hx;
    hi[1] = hy;
    hi[2] = hz;
    seen  = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      // even planes add row p/2 to the w row, odd planes subtract it
      for (int c = 0; c < NUM_COLS; c++) begin
        if (p % 2 == 1) begin
          plane[c] = matrix_coeff(c, W_ROW) - matrix_coeff(c, p / 2);
        end else begin
          plane[c] = matrix_coeff(c, W_ROW) + matrix_coeff(c, p / 2);
        end
      end
      // bring the w term to the Q.16 scale of the products
      acc = plane[NUM_AXES] * 256;
      for (int a = 0; a < NUM_AXES; a++) begin
        acc += plane[a] * ((plane[a] >= 0) ? hi[a] : lo[a]);
      end
      if (acc < 0) seen = 1'b0;
    end
    return seen;
  endfunction

  // follow register writes, predict on input transfers, compare on output
  always @(posedge clk) begin
    logic want;
    if (rst) begin
      for (int c = 0; c < NUM_COLS; c++) mat_col[c] = RESET_COL[c];
      visibility_due.delete();
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_MATRIX_COL0: mat_col[0] = cfg_data;
          REG_MATRIX_COL1: mat_col[1] = cfg_data;
          REG_MATRIX_COL2: mat_col[2] = cfg_data;
          REG_MATRIX_COL3: mat_col[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        visibility_due.push_back(box_visible(min_x, min_y, min_z, max_x, max_y, max_z));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (visibility_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d: unexpected transfer, visible=%0b", results_seen, visible);
          end
        end else begin
          want = visibility_due.pop_front();
          if (visible !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d: visible expected %0b, got %0b",
                       results_seen, want, visible);
            end
          end
        end
      end
    end
    pending <= visibility_due.size();
  end

endmodule

@@ bench/frustum_box_cull_test.sv @@
// ----------------------------------------------------------------------------
// frustum_box_cull_test: stimulus and verdict for the frustum box cull block
// Runs directed boxes at the coordinate extremes and against degenerate
// matrices, then phases of random boxes under a series of matrices, with
// random idle bursts on both channels. The checker does the comparison.
// ----------------------------------------------------------------------------
module frustum_box_cull_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fbc_pkg::*;

  localparam int COORD_WIDTH = 24;
  localparam int COEFF_WIDTH = 16;
  localparam int LATENCY     = 12;
  localparam int NUM_PHASES  = 12;
  localparam int WIDE_COUNT  = 160;
  localparam int FILL_COUNT  = 40;
  localparam int CMAX        = 2 ** (COORD_WIDTH - 1) - 1;
  localparam int CMIN        = -(2 ** (COORD_WIDTH - 1));

  typedef logic [NUM_COLS-1:0][CFG_DATA_W-1:0] matrix_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] min_x;
    logic [COORD_WIDTH-1:0] min_y;
    logic [COORD_WIDTH-1:0] min_z;
    logic [COORD_WIDTH-1:0] max_x;
    logic [COORD_WIDTH-1:0] max_y;
    logic [COORD_WIDTH-1:0] max_z;
  } box_t;

  typedef enum {
    MAT_SCALE,
    MAT_PERSPECTIVE,
    MAT_SMALL,
    MAT_FULL,
    MAT_ZERO,
    MAT_MAX,
    MAT_MIN
  } mat_kind_t;

  const reg_index_t COL_REG [NUM_COLS] = '{
    REG_MATRIX_COL0, REG_MATRIX_COL1, REG_MATRIX_COL2, REG_MATRIX_COL3
  };

  mat_kind_t phase_plan [NUM_PHASES] = '{
    MAT_PERSPECTIVE, MAT_SMALL, MAT_FULL, MAT_SCALE, MAT_PERSPECTIVE, MAT_MAX,
    MAT_SMALL, MAT_MIN, MAT_PERSPECTIVE, MAT_FULL, MAT_ZERO, MAT_PERSPECTIVE
  };

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_INDEX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic signed [COORD_WIDTH-1:0] min_x     = '0;
  logic signed [COORD_WIDTH-1:0] min_y     = '0;
  logic signed [COORD_WIDTH-1:0] min_z     = '0;
  logic signed [COORD_WIDTH-1:0] max_x     = '0;
  logic signed [COORD_WIDTH-1:0] max_y     = '0;
  logic signed [COORD_WIDTH-1:0] max_z     = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b1;
  logic                          visible;

  int pending;
  int mismatches;
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int sink_hold      = 0;

  frustum_box_cull #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEFF_WIDTH(COEFF_WIDTH)
  ) DUT (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .min_x, .min_y, .min_z, .max_x, .max_y, .max_z,
    .out_valid, .out_ready, .visible
  );

  frustum_box_cull_check #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEFF_WIDTH(COEFF_WIDTH)
  ) cull_check (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .min_x, .min_y, .min_z, .max_x, .max_y, .max_z,
    .out_valid, .out_ready, .visible,
    .pending, .mismatches
  );

  always #4 clk = ~clk;

  // stall the result channel in bursts at random
  always @(posedge clk) begin
    if (rst || sink_stall_pct == 0) begin
      out_ready <= 1'b1;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      out_ready <= 1'b0;
      sink_hold <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic box_t mk_box(input int lx, ly, lz, hx, hy, hz);
    box_t b;
    b.min_x = COORD_WIDTH'(lx);
    b.min_y = COORD_WIDTH'(ly);
    b.min_z = COORD_WIDTH'(lz);
    b.max_x = COORD_WIDTH'(hx);
    b.max_y = COORD_WIDTH'(hy);
    b.max_z = COORD_WIDTH'(hz);
    return b;
  endfunction

  // mostly boxes around the origin at a random scale, some full-range,
  // and now and then with min and max exchanged
  function automatic box_t random_box();
    int lo [NUM_AXES];
    int hi [NUM_AXES];
    int span, mid, half, tmp;
    bit full, flip;
    span = 1 << $urandom_range(2, 20);
    full = ($urandom_range(0, 3) == 0);
    flip = ($urandom_range(0, 7) == 0);
    for (int a = 0; a < NUM_AXES; a++) begin
      if (full) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else begin
        mid   = int'($urandom_range(0, 2 * span)) - span;
        half  = $urandom_range(0, span);
        lo[a] = mid - half;
        hi[a] = mid + half;
        if (flip) begin
          tmp   = lo[a];
          lo[a] = hi[a];
          hi[a] = tmp;
        end
      end
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  function automatic matrix_t put_coeff(input matrix_t m, input int col, row, val);
    m[col][FIELD_STRIDE*row +: FIELD_STRIDE] = FIELD_STRIDE'(val);
    return m;
  endfunction

  function automatic int signed_pick(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic matrix_t make_matrix(input mat_kind_t kind);
    matrix_t m;
    m = '0;
    case (kind)
      MAT_SCALE: begin
        for (int c = 0; c < NUM_COLS; c++) m = put_coeff(m, c, c, $urandom_range(64, 1024));
      end
      MAT_PERSPECTIVE: begin
        // w row picks up -z, so boxes in front of the eye pass
        m = put_coeff(m, 0, 0, $urandom_range(128, 768));
        m = put_coeff(m, 1, 1, $urandom_range(128, 768));
        m = put_coeff(m, 2, 2, signed_pick(512));
        m = put_coeff(m, 3, 2, signed_pick(2048));
        m = put_coeff(m, 3, 0, signed_pick(256));
        m = put_coeff(m, 3, 1, signed_pick(256));
        m = put_coeff(m, 2, W_ROW, -256);
        m = put_coeff(m, 3, W_ROW, signed_pick(64));
      end
      MAT_SMALL: begin
        for (int c = 0; c < NUM_COLS; c++) begin
          for (int r = 0; r < NUM_COLS; r++) m = put_coeff(m, c, r, signed_pick(512));
        end
      end
      MAT_FULL: begin
        for (int c = 0; c < NUM_COLS; c++) m[c] = {$urandom, $urandom};
      end
      MAT_MAX: m = {(NUM_COLS * NUM_COLS){16'h7fff}};
      MAT_MIN: m = {(NUM_COLS * NUM_COLS){16'h8000}};
      default: m = '0;
    endcase
    return m;
  endfunction

  // hold the box until it is taken, then maybe idle for a short burst
  task automatic feed(input box_t b);
    in_valid <= 1'b1;
    min_x    <= b.min_x;
    min_y    <= b.min_y;
    min_z    <= b.min_z;
    max_x    <= b.max_x;
    max_y    <= b.max_y;
    max_z    <= b.max_z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // write all four columns in a rotated order, optionally with a stray index
  task automatic load_matrix(input matrix_t m, input bit stray);
    int first, c;
    first = $urandom_range(0, NUM_COLS - 1);
    for (int k = 0; k < NUM_COLS; k++) begin
      c = (first + k) % NUM_COLS;
      write_reg(COL_REG[c], m[c]);
      if (stray && k == 1) begin
        write_reg(CFG_INDEX_W'(NUM_COLS + $urandom_range(0, 2 ** CFG_INDEX_W - 1 - NUM_COLS)),
                  {$urandom, $urandom});
      end
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int count;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // identity after reset: visible only where the box meets the unit cube
    feed(mk_box(0, 0, 0, 0, 0, 0));
    feed(mk_box(-256, -256, -256, 256, 256, 256));
    feed(mk_box(-1000, -10, -10, -256, 10, 10));
    feed(mk_box(-1000, -10, -10, -257, 10, 10));
    feed(mk_box(-10, 257, -10, 10, 300, 10));
    feed(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    feed(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    feed(mk_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    feed(mk_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    feed(mk_box(100, 100, 100, -100, -100, -100));
    drain();

    // all-zero planes: every sum is zero
    load_matrix(make_matrix(MAT_ZERO), 1'b1);
    feed(random_box());
    feed(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    drain();

    // largest and smallest coefficients, minus planes collapse to zero
    load_matrix(make_matrix(MAT_MAX), 1'b0);
    feed(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    feed(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    feed(mk_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    drain();
    load_matrix(make_matrix(MAT_MIN), 1'b1);
    feed(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    feed(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    feed(mk_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));

    // random phases; the last two run without idle bursts
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      load_matrix(make_matrix(phase_plan[ph]), ph % 3 == 0);
      if (ph >= NUM_PHASES - 2) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct    = $urandom_range(0, 2) * 15;
        sink_stall_pct = $urandom_range(0, 2) * 15;
      end
      if (phase_plan[ph] inside {MAT_ZERO, MAT_MAX, MAT_MIN}) count = FILL_COUNT;
      else count = WIDE_COUNT;
      for (int i = 0; i < count; i++) begin
        if (ph == 1 && i == count / 2) drain();
        feed(random_box());
      end
    end
    drain();

    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // bound the run well beyond the slowest legal schedule
  initial begin
    #(2_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/fbc_pkg.sv
src/fbc_cell.sv
src/frustum_box_cull.sv
bench/frustum_box_cull_check.sv
bench/frustum_box_cull_test.sv
